FILE: rtl/tdc_fine_time_histogram_calibrator_defines.svh
// ----------------------------------------------------------------------------
// tdc fine-time histogram calibrator assertion macros
// shared concurrent check forms, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef TDC_FINE_TIME_HISTOGRAM_CALIBRATOR_DEFINES_SVH
`define TDC_FINE_TIME_HISTOGRAM_CALIBRATOR_DEFINES_SVH

// same-cycle implication
`define TDC_FHC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdc_fhc: check failed");

// next-cycle implication
`define TDC_FHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdc_fhc: check failed");

`endif

FILE: rtl/tdc_fhc_pkg.sv
// ----------------------------------------------------------------------------
// tdc fine-time histogram calibrator package
// field widths, opcodes and item types shared by the interface and the block
// ----------------------------------------------------------------------------
package tdc_fhc_pkg;

    localparam int OPCODE_W  = 1;
    localparam int BOARD_W   = 4;
    localparam int CHANNEL_W = 7;
    localparam int FT_W      = 10;
    localparam int CAL_W     = 42;
    localparam int COUNT_W   = 32;

    localparam logic [OPCODE_W-1:0] OP_HIT  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [BOARD_W-1:0]   board;
        logic [CHANNEL_W-1:0] channel;
        logic [FT_W-1:0]      fine_time;
        logic                 odd_hit;
        logic [FT_W-1:0]      read_bin;
    } req_t;

    typedef struct packed {
        logic [CAL_W-1:0] cal_value;
        logic             fired_flag;
    } rsp_t;

endpackage

FILE: rtl/tdc_fhc_if.sv
// ----------------------------------------------------------------------------
// tdc fine-time histogram calibrator stream interface
// valid/ready channel carrying one item per handshake
// ----------------------------------------------------------------------------
interface tdc_fhc_if #(
    parameter type item_t = logic
);

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/tdc_fine_time_histogram_calibrator.sv
// ----------------------------------------------------------------------------
// tdc fine-time histogram calibrator
// per-channel fine-time code-density histogram with cumulative readback
// ----------------------------------------------------------------------------
//  channel  dir  item type            purpose
//  req      in   tdc_fhc_pkg::req_t   hit to record or bin to read
//  rsp      out  tdc_fhc_pkg::rsp_t   calibration value and fired flag
//
//  after reset a clearing pass zeroes all BOARDS*CHANNELS*NUM_BINS counter
//  entries (356400 by default), one entry a cycle; req is not ready then
//  an in-range hit passes accept, base address, counter read, counter write
//  a read passes accept, base address, a walk in which one shared 42-bit
//  accumulator steps through every bin of the channel over the single
//  memory read port, and the load of rsp in DONE
//  a read of an out-of-range channel skips the walk; a finished result waits
//  in DONE while the rsp register is still held by a stalled sink
// ----------------------------------------------------------------------------
`include "tdc_fine_time_histogram_calibrator_defines.svh"

module tdc_fine_time_histogram_calibrator #(
    parameter int BOARDS   = 9,
    parameter int CHANNELS = 66,
    parameter int NUM_BINS = 600
) (
    input  logic       clk,
    input  logic       rst_n,
    tdc_fhc_if.sink    req,
    tdc_fhc_if.source  rsp
);

    localparam int NCH    = BOARDS * CHANNELS;
    localparam int TOTAL  = NCH * NUM_BINS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int BCNT_W = $clog2(NUM_BINS + 1);
    localparam int FT_W   = tdc_fhc_pkg::FT_W;
    localparam int CAL_W  = tdc_fhc_pkg::CAL_W;
    localparam int CNT_W  = tdc_fhc_pkg::COUNT_W;
    localparam int BRD_W  = tdc_fhc_pkg::BOARD_W;
    localparam int CHN_W  = tdc_fhc_pkg::CHANNEL_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_BASE   = 3'd2;
    localparam logic [2:0] ST_HIT_RD = 3'd3;
    localparam logic [2:0] ST_HIT_WR = 3'd4;
    localparam logic [2:0] ST_WALK   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg;

    logic               op_reg;
    logic               bad_reg;
    logic               odd_reg;
    logic [CH_W-1:0]    ch_idx_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [BIN_W-1:0]   ft_reg;
    logic [FT_W-1:0]    rb_reg;
    logic               fired_q_reg;
    logic [CNT_W-1:0]   cnt_q_reg;

    logic [BCNT_W-1:0]  issue_cnt_reg;
    logic               pend_reg;
    logic [BIN_W-1:0]   pend_bin_reg;
    logic [CAL_W-1:0]   sum_reg;
    logic [BIN_W-1:0]   last_reg;
    logic               any_nz_reg;
    logic               pos_reg;

    logic               out_valid_reg;
    tdc_fhc_pkg::rsp_t  out_data_reg;

    logic [CNT_W-1:0]   cnt_mem [TOTAL];
    logic               fired_mem [NCH];

    logic               accept;
    logic               in_ok;
    logic               ft_ok;
    logic               issue_more;
    logic               walk_done;
    logic               out_free;
    logic               cnt_we;
    logic               cnt_re;
    logic [ADDR_W-1:0]  cnt_waddr;
    logic [ADDR_W-1:0]  cnt_raddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic               in_rb_range;
    tdc_fhc_pkg::rsp_t  result;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign in_ok     = ({1'b0, req.data.board} < (BRD_W + 1)'(BOARDS))
                    && ({1'b0, req.data.channel} < (CHN_W + 1)'(CHANNELS));
    assign ft_ok     = {1'b0, req.data.fine_time} < (FT_W + 1)'(NUM_BINS);

    assign issue_more = issue_cnt_reg < BCNT_W'(NUM_BINS);
    assign walk_done  = !issue_more && !pend_reg;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign in_rb_range = (FT_W + 1)'(pend_bin_reg) <= {1'b0, rb_reg};

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // counter memory port control
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = base_reg + ADDR_W'(ft_reg);
        cnt_wdata = (&cnt_q_reg) ? cnt_q_reg : cnt_q_reg + CNT_W'(1);
        cnt_re    = 1'b0;
        cnt_raddr = base_reg + ADDR_W'(ft_reg);
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_cnt_reg;
                cnt_wdata = '0;
            end
            ST_HIT_RD:
            begin
                cnt_re = 1'b1;
            end
            ST_HIT_WR:
            begin
                cnt_we = 1'b1;
            end
            ST_WALK:
            begin
                cnt_re    = issue_more;
                cnt_raddr = base_reg + ADDR_W'(issue_cnt_reg);
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_q_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR && clr_cnt_reg < ADDR_W'(NCH))
        begin
            fired_mem[clr_cnt_reg[CH_W-1:0]] <= 1'b0;
        end
        else if (state_reg == ST_HIT_WR && odd_reg)
        begin
            fired_mem[ch_idx_reg] <= 1'b1;
        end
        if (state_reg == ST_BASE)
        begin
            fired_q_reg <= fired_mem[ch_idx_reg];
        end
    end

    // result selection
    always_comb
    begin
        result = '0;
        if (!bad_reg)
        begin
            result.fired_flag = fired_q_reg;
            if ({1'b0, rb_reg} >= (FT_W + 1)'(NUM_BINS))
            begin
                result.cal_value = '0;
            end
            else if ({1'b0, rb_reg} < (FT_W + 1)'(last_reg))
            begin
                result.cal_value = sum_reg;
            end
            else
            begin
                result.cal_value = CAL_W'(pos_reg);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(TOTAL - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.data.opcode == tdc_fhc_pkg::OP_HIT)
                    begin
                        state_next = (in_ok && ft_ok) ? ST_BASE : ST_IDLE;
                    end
                    else
                    begin
                        state_next = in_ok ? ST_BASE : ST_DONE;
                    end
                end
            end
            ST_BASE:
            begin
                state_next = (op_reg == tdc_fhc_pkg::OP_HIT) ? ST_HIT_RD : ST_WALK;
            end
            ST_HIT_RD:
            begin
                state_next = ST_HIT_WR;
            end
            ST_HIT_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            issue_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (state_reg == ST_BASE)
            begin
                issue_cnt_reg <= '0;
                pend_reg      <= 1'b0;
            end
            else if (state_reg == ST_WALK)
            begin
                pend_reg <= issue_more;
                if (issue_more)
                begin
                    issue_cnt_reg <= issue_cnt_reg + BCNT_W'(1);
                end
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and walk datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.data.opcode;
            bad_reg    <= !in_ok;
            odd_reg    <= req.data.odd_hit;
            ft_reg     <= BIN_W'(req.data.fine_time);
            rb_reg     <= req.data.read_bin;
            ch_idx_reg <= CH_W'(32'(req.data.board) * CHANNELS + 32'(req.data.channel));
        end
        if (state_reg == ST_BASE)
        begin
            base_reg   <= ADDR_W'(32'(ch_idx_reg) * NUM_BINS);
            sum_reg    <= '0;
            last_reg   <= '0;
            any_nz_reg <= 1'b0;
            pos_reg    <= 1'b0;
        end
        if (state_reg == ST_WALK)
        begin
            pend_bin_reg <= BIN_W'(issue_cnt_reg);
            if (pend_reg)
            begin
                if (in_rb_range)
                begin
                    sum_reg <= sum_reg + CAL_W'(cnt_q_reg);
                end
                if (cnt_q_reg != '0)
                begin
                    any_nz_reg <= 1'b1;
                    if (pend_bin_reg != '0)
                    begin
                        last_reg <= pend_bin_reg;
                        pos_reg  <= any_nz_reg;
                    end
                end
            end
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg <= result;
        end
    end

    `TDC_FHC_ASSERT_IMP(a_clear_blocks_traffic, state_reg == ST_CLEAR, !req.ready && !rsp.valid)
    `TDC_FHC_ASSERT_NEXT(a_hit_gives_no_item, accept && req.data.opcode == tdc_fhc_pkg::OP_HIT, !$rose(rsp.valid))
    `TDC_FHC_ASSERT_IMP(a_hit_write_nonzero, state_reg == ST_HIT_WR && cnt_we, cnt_wdata != '0)
    `TDC_FHC_ASSERT_IMP(a_pending_only_in_walk, pend_reg, state_reg == ST_WALK)
    `TDC_FHC_ASSERT_IMP(a_item_loaded_from_done, $rose(rsp.valid), $past(state_reg) == ST_DONE)

endmodule

FILE: test/tdc_fine_time_histogram_calibrator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc fine-time histogram calibrator testbench
// feeds hit and bin-read items through the req channel with random gaps and
// random rsp back-pressure (one long hold-off to fill the block), keeps its
// own copy of every channel histogram and fired flag, and checks each
// calibration value and fired flag against that copy in arrival order
// ----------------------------------------------------------------------------
module tdc_fine_time_histogram_calibrator_tb;

    localparam int BOARDS     = 9;
    localparam int CHANNELS   = 66;
    localparam int NUM_BINS   = 600;
    localparam int NUM_ITEMS  = 1000;
    localparam int HOT_COUNT  = 6;
    localparam int HOLD_OFF   = 2500;
    localparam int HOLD_AFTER = 30;
    localparam int CAL_W      = tdc_fhc_pkg::CAL_W;
    localparam int FT_W       = tdc_fhc_pkg::FT_W;

    logic clk = 1'b0;
    logic rst_n;

    tdc_fhc_if #(.item_t(tdc_fhc_pkg::req_t)) req_ch ();
    tdc_fhc_if #(.item_t(tdc_fhc_pkg::rsp_t)) rsp_ch ();

    tdc_fine_time_histogram_calibrator #(
        .BOARDS   (BOARDS),
        .CHANNELS (CHANNELS),
        .NUM_BINS (NUM_BINS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    int unsigned bin_tally [BOARDS*CHANNELS*NUM_BINS];
    bit          fired_seen [BOARDS*CHANNELS];

    tdc_fhc_pkg::req_t items_to_send [$];
    tdc_fhc_pkg::rsp_t pending_cal_results [$];

    int unsigned error_count;
    int unsigned results_seen;
    int unsigned hits_recorded;
    int unsigned hits_dropped;
    int unsigned reads_issued;
    int unsigned sent_count;
    int unsigned send_gap;
    int unsigned hold_left;
    bit          pressure_done;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tdc_fhc_pkg::req_t make_item(logic op, int unsigned b, int unsigned c,
                                                    int unsigned ft, logic odd,
                                                    int unsigned rb);
        tdc_fhc_pkg::req_t it;
        it.opcode    = op;
        it.board     = b[tdc_fhc_pkg::BOARD_W-1:0];
        it.channel   = c[tdc_fhc_pkg::CHANNEL_W-1:0];
        it.fine_time = ft[FT_W-1:0];
        it.odd_hit   = odd;
        it.read_bin  = rb[FT_W-1:0];
        return it;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic bit channel_ok(tdc_fhc_pkg::req_t it);
        return it.board < BOARDS && it.channel < CHANNELS;
    endfunction

    function automatic tdc_fhc_pkg::rsp_t calibration_value_of(tdc_fhc_pkg::req_t it);
        tdc_fhc_pkg::rsp_t r;
        int unsigned       slot;
        int unsigned       base;
        int unsigned       last_bin;
        logic [CAL_W-1:0]  sum;
        r = '0;
        if (!channel_ok(it))
            return r;
        slot = int'(it.board) * CHANNELS + int'(it.channel);
        base = slot * NUM_BINS;
        r.fired_flag = fired_seen[slot];
        if (it.read_bin >= NUM_BINS)
            return r;
        last_bin = 0;
        for (int k = 1; k < NUM_BINS; k++)
            if (bin_tally[base + k] != 0)
                last_bin = k;
        sum = '0;
        if (it.read_bin < last_bin)
        begin
            for (int k = 0; k <= int'(it.read_bin); k++)
                sum += CAL_W'(bin_tally[base + k]);
            r.cal_value = sum;
        end
        else if (last_bin != 0)
        begin
            for (int k = 0; k < int'(last_bin); k++)
                sum += CAL_W'(bin_tally[base + k]);
            r.cal_value = (sum != '0) ? CAL_W'(1) : '0;
        end
        return r;
    endfunction

    task automatic absorb_item(tdc_fhc_pkg::req_t it);
        int unsigned slot;
        int unsigned idx;
        if (it.opcode == tdc_fhc_pkg::OP_READ)
        begin
            pending_cal_results.push_back(calibration_value_of(it));
            reads_issued++;
        end
        else if (channel_ok(it) && it.fine_time < NUM_BINS)
        begin
            slot = int'(it.board) * CHANNELS + int'(it.channel);
            idx  = slot * NUM_BINS + int'(it.fine_time);
            if (bin_tally[idx] != 32'hFFFF_FFFF)
                bin_tally[idx]++;
            if (it.odd_hit)
                fired_seen[slot] = 1'b1;
            hits_recorded++;
        end
        else
            hits_dropped++;
    endtask

    task automatic report_mismatch(string what, logic [CAL_W-1:0] want,
                                   logic [CAL_W-1:0] got);
        $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
        error_count++;
    endtask

    task automatic check_result(tdc_fhc_pkg::rsp_t got);
        tdc_fhc_pkg::rsp_t want;
        if (pending_cal_results.size() == 0)
        begin
            report_mismatch("result with no read outstanding", '0, got.cal_value);
            return;
        end
        want = pending_cal_results.pop_front();
        results_seen++;
        if (got.cal_value !== want.cal_value)
            report_mismatch("cal_value", want.cal_value, got.cal_value);
        if (got.fired_flag !== want.fired_flag)
            report_mismatch("fired_flag", CAL_W'(want.fired_flag), CAL_W'(got.fired_flag));
    endtask

    // request side driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            send_gap     <= 0;
            sent_count   <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (send_gap != 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end
            else if (items_to_send.size() != 0)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= items_to_send.pop_front();
                sent_count   <= sent_count + 1;
                send_gap     <= ((sent_count % 200) < 40) ? 0 : gap_len();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            absorb_item(req_ch.data);
    end

    // response side monitor and back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready  <= 1'b0;
            hold_left     <= 0;
            pressure_done <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_result(rsp_ch.data);
            if (!pressure_done && results_seen >= HOLD_AFTER)
            begin
                pressure_done <= 1'b1;
                hold_left     <= HOLD_OFF;
                rsp_ch.ready  <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if ((results_seen % 64) >= 12 && $urandom_range(0, 99) < 25)
            begin
                hold_left    <= gap_len();
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #60_000_000;
        $display("tdc_fine_time_histogram_calibrator_tb NOT OK");
        $finish;
    end

    initial
    begin
        int unsigned       hot_board [HOT_COUNT];
        int unsigned       hot_channel [HOT_COUNT];
        bit                hot_narrow [HOT_COUNT];
        int unsigned       useful;
        int unsigned       roll;
        int unsigned       h;
        int unsigned       b;
        int unsigned       c;
        int unsigned       ft;
        int unsigned       rb;
        tdc_fhc_pkg::req_t it;

        rst_n = 1'b0;

        // fresh channel, dropped hits, bad-channel reads
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, 0, 0, 0, 0, 0));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_HIT, 15, 127, 1023, 1, 1023));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_HIT, 0, 0, NUM_BINS, 1, 0));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_HIT, 0, CHANNELS, 5, 1, 0));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_HIT, BOARDS, 0, 5, 1, 0));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, 0, 0, 0, 0, 5));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, 15, 127, 1023, 1, 1023));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, BOARDS, 3, 0, 0, 2));
        // last channel of last board: cumulative, default and past-table reads
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_HIT, BOARDS-1, CHANNELS-1,
                                          0, 0, 1023));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_HIT, BOARDS-1, CHANNELS-1,
                                          0, 0, 0));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_HIT, BOARDS-1, CHANNELS-1,
                                          5, 1, 0));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_HIT, BOARDS-1, CHANNELS-1,
                                          NUM_BINS-1, 0, 1023));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, BOARDS-1, CHANNELS-1,
                                          1023, 1, 0));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, BOARDS-1, CHANNELS-1,
                                          0, 0, 5));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, BOARDS-1, CHANNELS-1,
                                          0, 0, NUM_BINS-2));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, BOARDS-1, CHANNELS-1,
                                          0, 0, NUM_BINS-1));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, BOARDS-1, CHANNELS-1,
                                          0, 0, 1023));
        // only bin zero filled
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_HIT, 0, 1, 0, 0, 0));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, 0, 1, 0, 0, 0));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, 0, 1, 0, 0, 700));
        // empty bins below the last one
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_HIT, 1, 2, 10, 0, 0));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, 1, 2, 0, 0, 3));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, 1, 2, 0, 0, 10));
        items_to_send.push_back(make_item(tdc_fhc_pkg::OP_READ, 1, 2, 0, 0, 11));

        hot_board[0]   = 0;
        hot_channel[0] = 0;
        hot_board[1]   = BOARDS - 1;
        hot_channel[1] = CHANNELS - 1;
        for (int i = 2; i < HOT_COUNT; i++)
        begin
            hot_board[i]   = $urandom_range(0, BOARDS - 1);
            hot_channel[i] = $urandom_range(0, CHANNELS - 1);
        end
        for (int i = 0; i < HOT_COUNT; i++)
            hot_narrow[i] = (i % 2) == 1;

        useful = 0;
        while (useful < NUM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                h = $urandom_range(0, HOT_COUNT - 1);
                b = hot_board[h];
                c = hot_channel[h];
            end
            else
            begin
                b = $urandom_range(0, BOARDS - 1);
                c = $urandom_range(0, CHANNELS - 1);
            end
            ft = hot_narrow[h] && roll < 70 ? $urandom_range(0, 15)
                                            : $urandom_range(0, NUM_BINS - 1);
            roll = $urandom_range(0, 99);
            if (roll < 40)
                rb = $urandom_range(0, 20);
            else if (roll < 85)
                rb = $urandom_range(0, NUM_BINS - 1);
            else
                rb = $urandom_range(0, 1023);
            if ($urandom_range(0, 99) < 10)
            begin
                b  = $urandom_range(0, 15);
                c  = $urandom_range(0, 127);
                ft = $urandom_range(0, 1023);
            end
            it = make_item($urandom_range(0, 99) < 25 ? tdc_fhc_pkg::OP_READ
                                                      : tdc_fhc_pkg::OP_HIT,
                           b, c, ft, $urandom_range(0, 7) == 0, rb);
            items_to_send.push_back(it);
            if (it.opcode == tdc_fhc_pkg::OP_READ
                || (channel_ok(it) && it.fine_time < NUM_BINS))
                useful++;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (items_to_send.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (pending_cal_results.size() != 0)
            @(posedge clk);
        repeat (NUM_BINS + 50) @(posedge clk);

        $display("sent %0d hits (%0d of them out of range) and %0d bin reads",
                 hits_recorded + hits_dropped, hits_dropped, reads_issued);
        $display("checked %0d calibration results, %0d mismatches",
                 results_seen, error_count);
        if (error_count == 0)
            $display("tdc_fine_time_histogram_calibrator_tb OK");
        else
            $display("tdc_fine_time_histogram_calibrator_tb NOT OK");
        $finish;
    end

endmodule
